/* rtl/tprd_pkg.sv */
// Shared types and constants for the TLS plaintext record deframer.
package tprd_pkg;

   localparam logic [7:0]  TYPE_CCS       = 8'd20;
   localparam logic [7:0]  TYPE_ALERT     = 8'd21;
   localparam logic [7:0]  TYPE_HANDSHAKE = 8'd22;
   localparam logic [7:0]  TYPE_APPDATA   = 8'd23;
   localparam logic [7:0]  CCS_VALUE      = 8'h01;
   localparam logic [15:0] MAX_FRAG_RESET = 16'h4000;

   localparam logic RESULT_PAYLOAD   = 1'b0;
   localparam logic RESULT_ERROR     = 1'b1;
   localparam logic RECORD_HANDSHAKE = 1'b0;
   localparam logic RECORD_ALERT     = 1'b1;

   localparam logic REG_SKIP_AT_START = 1'b0;
   localparam logic REG_MAX_FRAG_LEN  = 1'b1;

   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_TYPE  = 3'd1,
      ERR_LONG  = 3'd2,
      ERR_EMPTY = 3'd3,
      ERR_CCS   = 3'd4
   } err_code_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_SKIP,
      PH_CCS_ONE,
      PH_CCS_BAD
   } phase_type;

   typedef struct packed {
      logic         result_kind;
      logic         record_kind;
      logic [7:0]   payload_byte;
      logic         last_in_record;
      logic [15:0]  record_version;
      err_code_type error_code;
   } rsp_type;

   typedef struct packed {
      logic        write_enable;
      logic        index;
      logic [15:0] write_data;
   } csr_write_type;

endpackage

/* rtl/tprd_front.sv */
// Front end: header gathering, record checks and payload classification.
module tprd_front
   import tprd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [7:0]    in_byte,
   input  csr_write_type csr,
   output logic          push,
   output rsp_type       push_data
);

   phase_type    phase_ff, phase_in;
   logic [2:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]   type_ff, type_in;
   logic [15:0]  version_ff, version_in;
   logic [15:0]  remain_ff, remain_in;
   logic         skip_ff, skip_in;
   logic         halt_ff, halt_in;
   logic [15:0]  max_len_ff, max_len_in;

   logic [15:0]  remain_dec;
   logic [15:0]  hdr_len;
   logic         pay_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
         type_ff    <= '0;
         version_ff <= '0;
         remain_ff  <= '0;
         skip_ff    <= 1'b0;
         halt_ff    <= 1'b0;
         max_len_ff <= MAX_FRAG_RESET;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         type_ff    <= type_in;
         version_ff <= version_in;
         remain_ff  <= remain_in;
         skip_ff    <= skip_in;
         halt_ff    <= halt_in;
         max_len_ff <= max_len_in;
      end
   end

   assign remain_dec = remain_ff - 16'd1;
   assign hdr_len    = {remain_ff[15:8], in_byte};
   assign pay_last   = (remain_ff <= 16'd1);

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      type_in    = type_ff;
      version_in = version_ff;
      remain_in  = remain_ff;
      skip_in    = skip_ff;
      halt_in    = halt_ff;
      max_len_in = max_len_ff;

      push                     = 1'b0;
      push_data                = '0;
      push_data.result_kind    = RESULT_PAYLOAD;
      push_data.record_kind    = RECORD_HANDSHAKE;
      push_data.record_version = version_ff;
      push_data.error_code     = ERR_NONE;

      if (in_valid && !halt_ff) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               push                     = 1'b1;
               push_data.record_kind    = (type_ff == TYPE_ALERT) ? RECORD_ALERT
                                                                  : RECORD_HANDSHAKE;
               push_data.payload_byte   = in_byte;
               push_data.last_in_record = pay_last;
               remain_in                = remain_dec;
               if (pay_last) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_SKIP: begin
               remain_in = remain_dec;
               if (remain_dec == 16'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_CCS_ONE: begin
               phase_in = PH_HEADER;
               if (in_byte != CCS_VALUE) begin
                  push                 = 1'b1;
                  push_data.result_kind = RESULT_ERROR;
                  push_data.error_code = ERR_CCS;
                  halt_in              = 1'b1;
               end
            end
            PH_CCS_BAD: begin
               remain_in = remain_dec;
               if (remain_dec == 16'd0) begin
                  push                  = 1'b1;
                  push_data.result_kind = RESULT_ERROR;
                  push_data.error_code  = ERR_CCS;
                  halt_in               = 1'b1;
                  phase_in              = PH_HEADER;
               end
            end
            default: begin
               phase_in = PH_HEADER;
               case (hdr_cnt_ff)
                  3'd0:    type_in    = in_byte;
                  3'd1:    version_in = {in_byte, 8'h00};
                  3'd2:    version_in = {version_ff[15:8], in_byte};
                  3'd3:    remain_in  = {in_byte, 8'h00};
                  default: remain_in  = hdr_len;
               endcase
               if (hdr_cnt_ff < 3'd4) begin
                  hdr_cnt_in = hdr_cnt_ff + 3'd1;
               end else begin
                  hdr_cnt_in = '0;
                  // header complete: judge it
                  if (skip_ff && type_ff == TYPE_APPDATA) begin
                     if (hdr_len != 16'd0) begin
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     if (skip_ff && type_ff != TYPE_CCS) begin
                        skip_in = 1'b0;
                     end
                     if (!(type_ff inside {TYPE_HANDSHAKE, TYPE_ALERT, TYPE_CCS})) begin
                        push                  = 1'b1;
                        push_data.result_kind = RESULT_ERROR;
                        push_data.error_code  = ERR_TYPE;
                        halt_in               = 1'b1;
                     end else if (hdr_len > max_len_ff) begin
                        push                  = 1'b1;
                        push_data.result_kind = RESULT_ERROR;
                        push_data.error_code  = ERR_LONG;
                        halt_in               = 1'b1;
                     end else if (hdr_len == 16'd0) begin
                        push                  = 1'b1;
                        push_data.result_kind = RESULT_ERROR;
                        push_data.error_code  = ERR_EMPTY;
                        halt_in               = 1'b1;
                     end else if (type_ff == TYPE_CCS) begin
                        phase_in = (hdr_len == 16'd1) ? PH_CCS_ONE : PH_CCS_BAD;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
            end
         endcase
      end

      // register writes must arrive only while idle; the block does not enforce it
      if (csr.write_enable) begin
         case (csr.index)
            REG_SKIP_AT_START: skip_in    = csr.write_data[0];
            REG_MAX_FRAG_LEN:  max_len_in = csr.write_data;
            default:           max_len_in = max_len_ff;
         endcase
      end
   end

   // an error report halts the parser on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      push && push_data.result_kind == RESULT_ERROR |=> halt_ff)
      else $error("error report did not halt the parser");

   assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> !push)
      else $error("request produced a result while halted");

   assert property (@(posedge clock) disable iff (reset)
      in_valid && !halt_ff && phase_ff == PH_PAYLOAD |-> push)
      else $error("payload byte dropped");

endmodule

/* rtl/tprd_queue.sv */
// Short result queue between the parser and the output stage.
module tprd_queue
   import tprd_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    pop,
   output rsp_type head,
   output logic    empty,
   output logic    full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rsp_type           store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_CNT);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result pushed into a full queue");

endmodule

/* rtl/tprd_back.sv */
// Back end: output register that presents queued results on the response channel.
module tprd_back
   import tprd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  rsp_type head,
   input  logic    empty,
   output logic    pop,
   input  logic    out_ready,
   output logic    out_valid,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic    load;

   // refill when the register is empty or its result is taken this cycle
   assign load     = !valid_ff || out_ready;
   assign pop      = load && !empty;
   assign valid_in = load ? !empty : valid_ff;
   assign data_in  = pop ? head : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/tls_plaintext_record_deframer.sv */
// TLS plaintext record deframer: top level.
//
// Requests carry one stream byte each (req_valid/req_ready). The block gathers
// the 5-byte record header, checks it, and emits handshake and alert payload
// bytes on the response channel (rsp_valid/rsp_ready), tagged with record kind,
// record version and a last-of-record flag. Headers, skipped application data
// and a good change-cipher-spec byte produce no response. The first error is
// reported once as a response with result_kind set; afterwards every request
// is accepted and dropped until reset.
// Throughput: one byte per cycle while req_ready is high; the parser does one
// small compare/decrement per byte. A payload byte passes from the parser
// through the queue and the output register to rsp.
// When the receiver stalls, results collect in a QUEUE_DEPTH-entry queue; once
// it is full, req_ready drops until the output side drains.
// Registers (csr_write_enable, csr_index, csr_write_data) must be written while
// idle, not enforced; writing skip_encrypted_at_start loads the live skip flag.
// Reset (synchronous, active high) returns to the header phase with skipping
// off and max_fragment_length at 16384; the queue and output register empty.
module tls_plaintext_record_deframer
   import tprd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic        rsp_record_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_in_record,
   output logic [15:0] rsp_record_version,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   csr_write_type csr;
   logic          push, pop, q_empty, q_full, req_accept;
   rsp_type       push_data, q_head, out_data;

   assign csr.write_enable = csr_write_enable;
   assign csr.index        = csr_index;
   assign csr.write_data   = csr_write_data;

   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   tprd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_byte   (req_stream_byte),
      .csr       (csr),
      .push      (push),
      .push_data (push_data)
   );

   tprd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   tprd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .empty     (q_empty),
      .pop       (pop),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data)
   );

   assign rsp_result_kind    = out_data.result_kind;
   assign rsp_record_kind    = out_data.record_kind;
   assign rsp_payload_byte   = out_data.payload_byte;
   assign rsp_last_in_record = out_data.last_in_record;
   assign rsp_record_version = out_data.record_version;
   assign rsp_error_code     = out_data.error_code;

endmodule
